### src/assert_macros.svh
// Assertion macros shared by the converter RTL.
// Included by files that carry concurrent assertions; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qte assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define QTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qte assertion failed (next cycle)");

`endif

### src/qte_pkg.sv
// Shared constants, width helpers and the CORDIC arctangent table for the
// quaternion to Euler angle converter. Depends on nothing.
package qte_pkg;

    // Default parameter values.
    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int CORDIC_STEPS_DEF   = 16;

    // Fixed formats.
    localparam int QUAT_W      = 16;
    localparam int ANGLE_W     = 16;
    localparam int MAT_FRAC    = 30;
    localparam int ANG_FRAC    = 16;
    localparam int ANG_TAB_LEN = 24;
    localparam int Z_W         = 32;

    // Pipeline depths.
    localparam int MAT_LAT    = 3;
    localparam int SQRT_STEPS = MAT_FRAC + 1;
    localparam int SQRT_LAT   = SQRT_STEPS + 1;
    localparam int SQRT_N_W   = 2 * MAT_FRAC + 1;
    localparam int SQRT_R_W   = 2 * MAT_FRAC + 2;

    // Angle constants in hundredths of a degree.
    localparam logic signed [ANGLE_W-1:0] ANGLE_90  = 16'sd9000;
    localparam logic signed [ANGLE_W-1:0] ANGLE_180 = 16'sd18000;

    // Gimbal window on |m21|: a*1000 > 999*one and a*1000 < 1001*one.
    localparam logic [63:0] GIMBAL_LO = (64'd999 << MAT_FRAC) / 64'd1000;
    localparam logic [63:0] GIMBAL_HI = ((64'd1001 << MAT_FRAC) - 64'd1) / 64'd1000;
    localparam logic [63:0] MAT_ONE   = 64'd1 << MAT_FRAC;

    // Width of the exact matrix terms with 2*f fraction bits.
    function automatic int raw_width(input int f);
        int r;
        r = 2 * f + 3;
        if (r < 36) begin
            r = 36;
        end
        return r;
    endfunction

    // Width of the matrix terms once rescaled to MAT_FRAC fraction bits.
    function automatic int work_width(input int f);
        return raw_width(f) - (2 * f - MAT_FRAC);
    endfunction

    // atan(2^-i) in units of 2^-16 hundredths of a degree.
    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = 32'sd294912000;
            1:  v = 32'sd174096719;
            2:  v = 32'sd91987925;
            3:  v = 32'sd46694507;
            4:  v = 32'sd23437865;
            5:  v = 32'sd11730358;
            6:  v = 32'sd5866610;
            7:  v = 32'sd2933484;
            8:  v = 32'sd1466765;
            9:  v = 32'sd733385;
            10: v = 32'sd366693;
            11: v = 32'sd183347;
            12: v = 32'sd91673;
            13: v = 32'sd45837;
            14: v = 32'sd22918;
            15: v = 32'sd11459;
            16: v = 32'sd5730;
            17: v = 32'sd2865;
            18: v = 32'sd1432;
            19: v = 32'sd716;
            20: v = 32'sd358;
            21: v = 32'sd179;
            22: v = 32'sd90;
            23: v = 32'sd45;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

### src/qte_if.sv
// Valid/ready channel interfaces for quaternion input and angle output words.
// Depends on qte_pkg for field widths.
interface qte_in_if import qte_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [QUAT_W-1:0]  quat_w;
    logic signed [QUAT_W-1:0]  quat_x;
    logic signed [QUAT_W-1:0]  quat_y;
    logic signed [QUAT_W-1:0]  quat_z;
    logic                      rotate_frame;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, rotate_frame,
                    input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, rotate_frame,
                    output ready);
endinterface

interface qte_out_if import qte_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [ANGLE_W-1:0]  angle_x;
    logic signed [ANGLE_W-1:0]  angle_y;
    logic signed [ANGLE_W-1:0]  angle_z;

    modport source (output valid, angle_x, angle_y, angle_z, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

### src/qte_delay.sv
// Enabled shift line that keeps side data aligned with the pipeline.
// Depends on nothing.
module qte_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_line [DEPTH];

    // Shift one place whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_line[k] <= '0;
            end
        end else if (i_en) begin
            r_line[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_data = r_line[DEPTH-1];

endmodule

### src/qte_matrix.sv
// Rotation-matrix front end: products, matrix terms, arcsine prep and
// gimbal detection over three register stages. Depends on qte_pkg.
module qte_matrix import qte_pkg::*; #(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    parameter int IN_W           = work_width(QUAT_FRAC_BITS_DEF) + 1
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [QUAT_W-1:0] i_w,
    input  logic signed [QUAT_W-1:0] i_x,
    input  logic signed [QUAT_W-1:0] i_y,
    input  logic signed [QUAT_W-1:0] i_z,
    output logic signed [IN_W-1:0]   o_v,
    output logic [MAT_FRAC-1:0]      o_mag,
    output logic                     o_sat,
    output logic                     o_gimbal,
    output logic                     o_v_neg,
    output logic signed [IN_W-1:0]   o_y_num,
    output logic signed [IN_W-1:0]   o_y_den,
    output logic signed [IN_W-1:0]   o_z_num,
    output logic signed [IN_W-1:0]   o_z_den
);

    localparam int RAW_W  = raw_width(QUAT_FRAC_BITS);
    localparam int WORK_W = IN_W - 1;
    localparam int D      = 2 * QUAT_FRAC_BITS - MAT_FRAC;
    localparam int SR     = (D >= 0) ? D : 0;
    localparam int SL     = (D < 0) ? -D : 0;
    localparam int PW     = 2 * QUAT_W;

    // Rescale an exact term to MAT_FRAC fraction bits, flooring on a right shift.
    function automatic logic signed [WORK_W-1:0] to_work(input logic signed [RAW_W-1:0] raw);
        logic signed [RAW_W-1:0] sh;
        sh = raw >>> SR;
        return WORK_W'(sh) <<< SL;
    endfunction

    // Stage 1: component products.
    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_xy <= i_x * i_y;
            r_wz <= i_w * i_z;
            r_xz <= i_x * i_z;
            r_wy <= i_w * i_y;
            r_yz <= i_y * i_z;
            r_wx <= i_w * i_x;
        end
    end

    // Stage 2: exact matrix terms, then rescale.
    logic signed [RAW_W-1:0]  one_raw;
    logic signed [RAW_W-1:0]  raw_m00, raw_m10, raw_m20, raw_m01, raw_m11, raw_m21, raw_m22;
    logic signed [WORK_W-1:0] r_m00, r_m10, r_m20, r_m01, r_m11, r_m21, r_m22;

    always_comb begin
        one_raw = RAW_W'(1) <<< (2 * QUAT_FRAC_BITS);
        raw_m00 = one_raw - ((RAW_W'(r_yy) + RAW_W'(r_zz)) <<< 1);
        raw_m10 = (RAW_W'(r_xy) - RAW_W'(r_wz)) <<< 1;
        raw_m20 = (RAW_W'(r_xz) + RAW_W'(r_wy)) <<< 1;
        raw_m01 = (RAW_W'(r_xy) + RAW_W'(r_wz)) <<< 1;
        raw_m11 = one_raw - ((RAW_W'(r_xx) + RAW_W'(r_zz)) <<< 1);
        raw_m21 = (RAW_W'(r_yz) - RAW_W'(r_wx)) <<< 1;
        raw_m22 = one_raw - ((RAW_W'(r_xx) + RAW_W'(r_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m00 <= to_work(raw_m00);
            r_m10 <= to_work(raw_m10);
            r_m20 <= to_work(raw_m20);
            r_m01 <= to_work(raw_m01);
            r_m11 <= to_work(raw_m11);
            r_m21 <= to_work(raw_m21);
            r_m22 <= to_work(raw_m22);
        end
    end

    // Stage 3: arcsine argument, its magnitude, and the atan2 pairs.
    logic signed [IN_W-1:0] n_v;
    logic signed [IN_W-1:0] n_abs;
    logic [63:0]            n_a64;
    logic                   n_gimbal;

    always_comb begin
        n_v      = -IN_W'(r_m21);
        n_abs    = r_m21[WORK_W-1] ? n_v : IN_W'(r_m21);
        n_a64    = 64'(unsigned'(n_abs));
        n_gimbal = (n_a64 > GIMBAL_LO) && (n_a64 <= GIMBAL_HI);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_v      <= n_v;
            o_mag    <= n_a64[MAT_FRAC-1:0];
            o_sat    <= (n_a64 >= MAT_ONE);
            o_gimbal <= n_gimbal;
            o_v_neg  <= n_v[IN_W-1];
            o_y_num  <= IN_W'(r_m20);
            o_y_den  <= IN_W'(r_m22);
            o_z_num  <= n_gimbal ? -IN_W'(r_m00) : IN_W'(r_m01);
            o_z_den  <= n_gimbal ? -IN_W'(r_m10) : IN_W'(r_m11);
        end
    end

endmodule

### src/qte_isqrt.sv
// Pipelined integer square root of one minus the squared arcsine argument,
// one result bit per stage. Depends on qte_pkg.
module qte_isqrt import qte_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [MAT_FRAC-1:0] i_mag,
    output logic [MAT_FRAC:0]   o_root
);

    logic [2*MAT_FRAC-1:0] r_sq;
    logic [SQRT_N_W-1:0]   r_n   [SQRT_STEPS];
    logic [SQRT_R_W-1:0]   r_res [SQRT_STEPS];

    // Square of the magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= i_mag * i_mag;
        end
    end

    // Restoring root steps, bit weight 4^(MAT_FRAC-k) at stage k.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SQRT_R_W-1:0] BIT = SQRT_R_W'(1) << (2 * (MAT_FRAC - k));
        logic [SQRT_N_W-1:0] n_in;
        logic [SQRT_R_W-1:0] res_in;
        logic [SQRT_R_W-1:0] trial;

        if (k == 0) begin : g_first
            assign n_in   = SQRT_N_W'(MAT_ONE * MAT_ONE) - SQRT_N_W'(r_sq);
            assign res_in = '0;
        end else begin : g_next
            assign n_in   = r_n[k-1];
            assign res_in = r_res[k-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (SQRT_R_W'(n_in) >= trial) begin
                    r_n[k]   <= n_in - trial[SQRT_N_W-1:0];
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_n[k]   <= n_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_root = r_res[SQRT_STEPS-1][MAT_FRAC:0];

endmodule

### src/qte_cordic.sv
// Pipelined vectoring CORDIC atan2 with pre-rotation, rounding to hundredths
// of a degree and saturation. Depends on qte_pkg.
module qte_cordic import qte_pkg::*; #(
    parameter int IN_W         = work_width(QUAT_FRAC_BITS_DEF) + 1,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [IN_W-1:0]    i_y,
    input  logic signed [IN_W-1:0]    i_x,
    output logic signed [ANGLE_W-1:0] o_angle
);

    localparam int CW = IN_W + 3;
    localparam logic signed [Z_W-1:0] Z_90 = Z_W'(ANGLE_90) <<< ANG_FRAC;

    logic signed [CW-1:0]  r_x    [CORDIC_STEPS+1];
    logic signed [CW-1:0]  r_y    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0] r_z    [CORDIC_STEPS+1];
    logic                  r_zero [CORDIC_STEPS+1];

    // Pre-rotation by 90 degrees into the right half plane.
    logic signed [CW-1:0] xe, ye;
    assign xe = CW'(i_x);
    assign ye = CW'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[IN_W-1] && !i_y[IN_W-1]) begin
                r_x[0] <= ye;
                r_y[0] <= -xe;
                r_z[0] <= Z_90;
            end else if (i_x[IN_W-1]) begin
                r_x[0] <= -ye;
                r_y[0] <= xe;
                r_z[0] <= -Z_90;
            end else begin
                r_x[0] <= xe;
                r_y[0] <= ye;
                r_z[0] <= '0;
            end
        end
    end

    // Micro-rotation stages driving y toward zero.
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
        localparam logic signed [Z_W-1:0] TAB = atan_entry(k);
        logic signed [CW-1:0] dx, dy;
        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[k+1] <= r_zero[k];
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + TAB;
                end else begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - TAB;
                end
            end
        end
    end

    // Round to the nearest hundredth and clamp to a half turn; a zero vector gives zero.
    logic signed [Z_W-1:0]     zr;
    logic signed [ANGLE_W-1:0] n_angle;

    always_comb begin
        zr = r_z[CORDIC_STEPS] + (Z_W'(1) <<< (ANG_FRAC - 1));
        n_angle = zr[Z_W-1:ANG_FRAC];
        if (r_zero[CORDIC_STEPS]) begin
            n_angle = '0;
        end else if (n_angle > ANGLE_180) begin
            n_angle = ANGLE_180;
        end else if (n_angle < -ANGLE_180) begin
            n_angle = -ANGLE_180;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= n_angle;
        end
    end

endmodule

### src/quaternion_to_euler_angles.sv
// Top level of the quaternion to Euler angle converter.
// Depends on qte_pkg, qte_if, qte_delay, qte_matrix, qte_isqrt, qte_cordic, assert_macros.svh.
//
// Usage:
//   i_quat carries one quaternion word per handshake (w, x, y, z in signed
//   fixed point, plus rotate_frame); o_angle returns one word of three angles
//   in hundredths of a degree for each quaternion, in order.
//   A word passes three matrix stages, one squaring stage and 31 square-root
//   stages, the CORDIC pipeline, and the output register.
//   Throughput is one word per cycle; every stage is a register and the three
//   CORDIC units for the x, y and z angles run side by side.
//   All stages move together; when o_angle holds a word that the receiver
//   does not take, the whole pipeline holds and i_quat.ready drops, and
//   nothing is lost or repeated. Otherwise a word is taken every cycle.
//   Reset clears the valid bits and the delay lines only; the block comes out
//   of reset empty and ready. There is no configuration and no state between words.
`include "assert_macros.svh"

module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qte_in_if.sink    i_quat,
    qte_out_if.source o_angle
);

    localparam int IN_W     = work_width(QUAT_FRAC_BITS) + 1;
    localparam int CORD_LAT = CORDIC_STEPS + 2;
    localparam int FULL_LAT = MAT_LAT + SQRT_LAT + CORD_LAT;

    logic en;
    logic r_out_valid;

    // The pipeline advances unless a finished word is stuck at the output.
    assign en           = !r_out_valid || o_angle.ready;
    assign i_quat.ready = en;

    // Valid and frame flag travel alongside the data.
    logic fin_valid, fin_rot;

    qte_delay #(.WIDTH(2), .DEPTH(FULL_LAT)) u_ctl_line (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_data ({i_quat.valid, i_quat.rotate_frame}),
        .o_data ({fin_valid, fin_rot})
    );

    // Matrix terms and arcsine prep.
    logic signed [IN_W-1:0] m_v, m_y_num, m_y_den, m_z_num, m_z_den;
    logic [MAT_FRAC-1:0]    m_mag;
    logic                   m_sat, m_gimbal, m_v_neg;

    qte_matrix #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS), .IN_W(IN_W)) u_matrix (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_w     (i_quat.quat_w),
        .i_x     (i_quat.quat_x),
        .i_y     (i_quat.quat_y),
        .i_z     (i_quat.quat_z),
        .o_v     (m_v),
        .o_mag   (m_mag),
        .o_sat   (m_sat),
        .o_gimbal(m_gimbal),
        .o_v_neg (m_v_neg),
        .o_y_num (m_y_num),
        .o_y_den (m_y_den),
        .o_z_num (m_z_num),
        .o_z_den (m_z_den)
    );

    // Cosine of the x angle from the square root.
    logic [MAT_FRAC:0] root;

    qte_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (m_mag),
        .o_root(root)
    );

    // Hold the atan2 operands while the root is formed.
    logic signed [IN_W-1:0] d_v, d_y_num, d_y_den, d_z_num, d_z_den;

    qte_delay #(.WIDTH(5 * IN_W), .DEPTH(SQRT_LAT)) u_pair_line (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_data ({m_v, m_y_num, m_y_den, m_z_num, m_z_den}),
        .o_data ({d_v, d_y_num, d_y_den, d_z_num, d_z_den})
    );

    // Flags for the final selection.
    logic fin_sat, fin_gimbal, fin_v_neg;

    qte_delay #(.WIDTH(3), .DEPTH(SQRT_LAT + CORD_LAT)) u_flag_line (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_data ({m_sat, m_gimbal, m_v_neg}),
        .o_data ({fin_sat, fin_gimbal, fin_v_neg})
    );

    // Three atan2 units in parallel.
    logic signed [ANGLE_W-1:0] c_x, c_y, c_z;

    qte_cordic #(.IN_W(IN_W), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (d_v),
        .i_x    (IN_W'(root)),
        .o_angle(c_x)
    );

    qte_cordic #(.IN_W(IN_W), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (d_y_num),
        .i_x    (d_y_den),
        .o_angle(c_y)
    );

    qte_cordic #(.IN_W(IN_W), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic_z (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (d_z_num),
        .i_x    (d_z_den),
        .o_angle(c_z)
    );

    // Saturated arcsine, gimbal pinning and the optional frame flip.
    logic signed [ANGLE_W-1:0] n_ax, n_ay, n_az;
    logic signed [ANGLE_W-1:0] r_ax, r_ay, r_az;

    always_comb begin
        n_ax = fin_sat ? (fin_v_neg ? -ANGLE_90 : ANGLE_90) : c_x;
        n_ay = fin_gimbal ? '0 : c_y;
        n_az = c_z;
        if (fin_rot) begin
            n_ax = -n_ax;
            n_ay = (n_ay > 0) ? (n_ay - ANGLE_180) : (n_ay + ANGLE_180);
            n_az = -n_az;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_az <= n_az;
        end
    end

    assign o_angle.valid   = r_out_valid;
    assign o_angle.angle_x = r_ax;
    assign o_angle.angle_y = r_ay;
    assign o_angle.angle_z = r_az;

    // Terms for the checks below.
    logic fin_take, y_in_range, x_quarter;

    assign fin_take   = en && fin_valid;
    assign y_in_range = (o_angle.angle_y >= -ANGLE_180) && (o_angle.angle_y <= ANGLE_180);
    assign x_quarter  = (o_angle.angle_x == ANGLE_90) || (o_angle.angle_x == -ANGLE_90);

    // A delivered y angle never leaves the half turn.
    `QTE_ASSERT_IMPLY(a_y_range, i_clk, i_rst_n, o_angle.valid, y_in_range)

    // In gimbal lock without the flip, y is pinned to zero.
    `QTE_ASSERT_NEXT(a_gimbal_y, i_clk, i_rst_n, fin_take && fin_gimbal && !fin_rot, r_ay == '0)

    // An out-of-range arcsine argument gives a quarter turn on x.
    `QTE_ASSERT_NEXT(a_asin_sat, i_clk, i_rst_n, fin_take && fin_sat, x_quarter)

endmodule

### sim/quaternion_to_euler_angles_tb.sv
// Self-checking testbench for the quaternion to Euler angle converter.
// Depends on qte_pkg, the qte_in_if/qte_out_if channel interfaces and the RTL top level;
// expected angles come from a bit-exact predictor kept in this file.
module quaternion_to_euler_angles_tb;
    import qte_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [ANGLE_W-1:0] ax;
        logic signed [ANGLE_W-1:0] ay;
        logic signed [ANGLE_W-1:0] az;
    } t_angles;

    localparam int     STEPS      = CORDIC_STEPS_DEF;
    localparam longint QUAT_ONE   = 64'sd1 <<< (2 * QUAT_FRAC_BITS_DEF);
    localparam longint UNIT_30    = 64'sd1 <<< MAT_FRAC;
    localparam int     IDLE_LIMIT = 3000;
    localparam int     DRAIN_WAIT = 70;
    localparam longint ATAN_STEP [0:15] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466765, 733385, 366693, 183347,
        91673, 45837, 22918, 11459
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qte_in_if  quat_ch ();
    qte_out_if angle_ch ();

    quaternion_to_euler_angles dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_ch),
        .o_angle (angle_ch)
    );

    always #10 i_clk = ~i_clk;

    t_angles expected_angles [$];
    int      error_count = 0;
    int      words_sent = 0;
    int      words_checked = 0;
    int      gimbal_words = 0;
    int      hold_cycles = 0;
    logic    steady = 1'b0;
    logic    quat_taken = 1'b0;

    // Vectoring CORDIC arctangent in hundredths of a degree.
    function automatic int atan2_hdeg(longint yy, longint xx);
        longint xv, yv, zv, t, dx, dy, r;
        xv = xx;
        yv = yy;
        zv = 0;
        if (xv == 0 && yv == 0) begin
            return 0;
        end
        if (xv < 0) begin
            t = xv;
            if (yv >= 0) begin
                xv = yv;
                yv = -t;
                zv = 64'sd9000 <<< ANG_FRAC;
            end else begin
                xv = -yv;
                yv = t;
                zv = -(64'sd9000 <<< ANG_FRAC);
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0) begin
                xv += dx;
                yv -= dy;
                zv += ATAN_STEP[i];
            end else begin
                xv -= dx;
                yv += dy;
                zv -= ATAN_STEP[i];
            end
        end
        r = (zv + (64'sd1 <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
        if (r > 18000) r = 18000;
        if (r < -18000) r = -18000;
        return int'(r);
    endfunction

    // Truncating integer square root.
    function automatic longint isqrt_trunc(bit [63:0] n);
        bit [63:0] res, b, rem;
        res = 0;
        rem = n;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // Arcsine as atan2(v, sqrt(1 - v*v)), saturating at plus or minus 90 degrees.
    function automatic int asin_hdeg(longint v);
        longint a;
        bit [63:0] c;
        a = (v < 0) ? -v : v;
        if (a >= UNIT_30) begin
            return (v > 0) ? 9000 : -9000;
        end
        c = (64'd1 << (2 * MAT_FRAC)) - 64'(a) * 64'(a);
        return atan2_hdeg(v, isqrt_trunc(c));
    endfunction

    // Full conversion of one quaternion word to the three angles.
    function automatic t_angles predict_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                               logic signed [15:0] qy, logic signed [15:0] qz,
                                               logic rot);
        longint w, x, y, z, m00, m10, m20, m01, m11, m21, m22, a;
        int ax, ay, az;
        t_angles res;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        // Matrix terms rescaled from 28 to 30 fraction bits.
        m00 = (QUAT_ONE - 2 * (y * y + z * z)) * 4;
        m10 = (2 * (x * y - w * z)) * 4;
        m20 = (2 * (x * z + w * y)) * 4;
        m01 = (2 * (x * y + w * z)) * 4;
        m11 = (QUAT_ONE - 2 * (x * x + z * z)) * 4;
        m21 = (2 * (y * z - w * x)) * 4;
        m22 = (QUAT_ONE - 2 * (x * x + y * y)) * 4;
        ax = asin_hdeg(-m21);
        a = (m21 < 0) ? -m21 : m21;
        if (a * 1000 > 999 * UNIT_30 && a * 1000 < 1001 * UNIT_30) begin
            ay = 0;
            az = atan2_hdeg(-m00, -m10);
        end else begin
            ay = atan2_hdeg(m20, m22);
            az = atan2_hdeg(m01, m11);
        end
        if (rot) begin
            ax = -ax;
            ay = (ay > 0) ? ay - 18000 : ay + 18000;
            az = -az;
        end
        res.ax = ax[15:0];
        res.ay = ay[15:0];
        res.az = az[15:0];
        return res;
    endfunction

    // Random gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Record each accepted quaternion word and its expected angles.
    always @(posedge i_clk) begin
        quat_taken <= quat_ch.valid && quat_ch.ready;
        if (i_rst_n && quat_ch.valid && quat_ch.ready) begin
            expected_angles.push_back(predict_angles(quat_ch.quat_w, quat_ch.quat_x,
                                                     quat_ch.quat_y, quat_ch.quat_z,
                                                     quat_ch.rotate_frame));
        end
    end

    // Compare each accepted angle word with the oldest expectation.
    always @(posedge i_clk) begin
        t_angles exp_a;
        if (i_rst_n && angle_ch.valid && angle_ch.ready) begin
            if (expected_angles.size() == 0) begin
                $error("unexpected angle word x=%0d y=%0d z=%0d",
                       angle_ch.angle_x, angle_ch.angle_y, angle_ch.angle_z);
                error_count++;
            end else begin
                exp_a = expected_angles.pop_front();
                words_checked++;
                if (angle_ch.angle_x !== exp_a.ax) begin
                    $error("angle_x expected %0d actual %0d", exp_a.ax, angle_ch.angle_x);
                    error_count++;
                end
                if (angle_ch.angle_y !== exp_a.ay) begin
                    $error("angle_y expected %0d actual %0d", exp_a.ay, angle_ch.angle_y);
                    error_count++;
                end
                if (angle_ch.angle_z !== exp_a.az) begin
                    $error("angle_z expected %0d actual %0d", exp_a.az, angle_ch.angle_z);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        angle_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                angle_ch.ready = 1'b0;
                hold_cycles--;
            end else if (steady || !i_rst_n) begin
                angle_ch.ready = i_rst_n;
            end else begin
                angle_ch.ready = 1'b1;
                if ($urandom_range(99) < 25) begin
                    angle_ch.ready = 1'b0;
                    if ($urandom_range(99) < 6) hold_cycles = $urandom_range(50, 10);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((quat_ch.valid && quat_ch.ready) || (angle_ch.valid && angle_ch.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
            if (idle >= IDLE_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("quaternion_to_euler_angles test failed");
                $finish;
            end
        end
    end

    // Offer one quaternion word after a random gap and wait until it is taken.
    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                             logic signed [15:0] qy, logic signed [15:0] qz, logic rot);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            quat_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        quat_ch.valid        = 1'b1;
        quat_ch.quat_w       = qw;
        quat_ch.quat_x       = qx;
        quat_ch.quat_y       = qy;
        quat_ch.quat_z       = qz;
        quat_ch.rotate_frame = rot;
        do begin
            @(negedge i_clk);
        end while (!quat_taken);
        // Leave valid high; the next call lowers it only if it idles.
        words_sent++;
    endtask

    task automatic wait_drained();
        quat_ch.valid = 1'b0;
        while (expected_angles.size() != 0) @(negedge i_clk);
    endtask

    // Random unit quaternion rounded to Q1.14.
    task automatic send_unit_quat(logic rot);
        real c [4];
        real n;
        logic signed [15:0] q [4];
        do begin
            n = 0.0;
            for (int i = 0; i < 4; i++) begin
                c[i] = (real'($urandom_range(65535)) - 32768.0) / 32768.0;
                n += c[i] * c[i];
            end
        end while (n < 0.01);
        n = $sqrt(n);
        for (int i = 0; i < 4; i++) q[i] = 16'($rtoi(c[i] / n * 16384.0 + (c[i] < 0 ? -0.5 : 0.5)));
        send_quat(q[0], q[1], q[2], q[3], rot);
    endtask

    // Quaternion near a pitch of plus or minus 90 degrees.
    task automatic send_gimbal_quat(logic rot);
        logic signed [15:0] a, b, s, t;
        a = 16'(11585 + $signed($urandom_range(24)) - 12);
        b = 16'(11585 + $signed($urandom_range(24)) - 12);
        s = 16'($signed($urandom_range(400)) - 200);
        t = 16'($signed($urandom_range(400)) - 200);
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
        gimbal_words++;
        if ($urandom_range(1)) send_quat(a, b, s, t, rot);
        else send_quat(s, t, a, b, rot);
    endtask

    task automatic send_raw_quat();
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // Axis rotations, extremes, zero vectors, saturating arcsine and gimbal lock.
    task automatic test_directed();
        for (int r = 0; r < 2; r++) begin
            send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0, r[0]);
            send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0, r[0]);
            send_quat(16'sd0, 16'sd0, -16'sd16384, 16'sd0, r[0]);
            send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384, r[0]);
            send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, r[0]);
            send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, r[0]);
            send_quat(16'sd16384, 16'sd16384, 16'sd0, 16'sd0, r[0]);
            send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0, r[0]);
            send_quat(16'sd0, 16'sd8192, 16'sd8192, 16'sd0, r[0]);
            send_quat(16'sd11585, 16'sd11585, 16'sd0, 16'sd0, r[0]);
            send_quat(16'sd11585, -16'sd11585, 16'sd0, 16'sd0, r[0]);
            send_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, r[0]);
        end
    endtask

    // Mostly unit quaternions, with gimbal-region and raw-bit words mixed in.
    task automatic test_random(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 70) send_unit_quat(1'($urandom));
            else if (r < 85) send_gimbal_quat(1'($urandom));
            else send_raw_quat();
        end
    endtask

    // Stretch with no idling on either side.
    task automatic test_steady_stream();
        steady = 1'b1;
        test_random(150);
        steady = 1'b0;
    endtask

    // Receiver holds off long enough that the pipeline fills and stalls the input.
    task automatic test_backpressure();
        steady = 1'b1;
        hold_cycles = 250;
        test_random(120);
        steady = 1'b0;
    endtask

    // Sender pauses until every expected word has come back.
    task automatic test_drain_pause();
        test_random(40);
        wait_drained();
        test_random(40);
    endtask

    initial begin
        quat_ch.valid        = 1'b0;
        quat_ch.quat_w       = '0;
        quat_ch.quat_x       = '0;
        quat_ch.quat_y       = '0;
        quat_ch.quat_z       = '0;
        quat_ch.rotate_frame = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(500);
        test_steady_stream();
        test_backpressure();
        test_drain_pause();
        test_random(500);

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Sent %0d quaternion words (%0d near gimbal lock), checked %0d angle words.",
                 words_sent, gimbal_words, words_checked);
        $display("Covered axis extremes, zero vectors, saturated pitch, frame rotation, stalls.");
        if (error_count == 0 && expected_angles.size() == 0) begin
            $display("quaternion_to_euler_angles test passed");
        end else begin
            if (expected_angles.size() != 0) begin
                $error("%0d expected angle words never arrived", expected_angles.size());
            end
            $display("quaternion_to_euler_angles test failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/qte_pkg.sv
src/qte_if.sv
src/qte_delay.sv
src/qte_matrix.sv
src/qte_isqrt.sv
src/qte_cordic.sv
src/quaternion_to_euler_angles.sv
sim/quaternion_to_euler_angles_tb.sv
